>>> hw/rtl/axof_pkg.sv
package axof_pkg;

	localparam int NUM_LANES  = 5;
	localparam int NUM_ROUNDS = 12;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = 1;
	localparam int PADDR_W    = 3;

	// register index taken from paddr[2]
	localparam logic REG_OUT_LEN = 1'b0;

	localparam logic [8:0] OUT_LEN_RESET = 9'd32;
	localparam logic [8:0] OUT_LEN_MAX   = 9'd256;

	typedef logic [NUM_LANES-1:0][63:0] lanes_t;

	localparam lanes_t IV_LANES = {
		64'he0547524db6f0bde, 64'h0ee0ea53416b58cc, 64'he7508fd780085631,
		64'hcc7ce6c75f1ef969, 64'hda82ce768d9447eb
	};

	// absorb: xor and permute; final: xor, permute, squeeze;
	// final_full: xor, permute, pad alone, permute, squeeze
	typedef enum logic [1:0] {
		CMD_ABSORB     = 2'd0,
		CMD_FINAL      = 2'd1,
		CMD_FINAL_FULL = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [63:0] word;
		cmd_kind_t   kind;
	} cmd_t;

	function automatic logic [63:0] rotr64(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// low n bytes set, n of 8 or more gives all ones
	function automatic logic [63:0] byte_mask(logic [3:0] n);
		return n[3] ? {64{1'b1}} : ~({64{1'b1}} << {n[2:0], 3'b000});
	endfunction

	// one round of the permutation
	function automatic lanes_t ascon_round(lanes_t s, logic [3:0] r);
		logic [63:0] x0, x1, x2, x3, x4;
		logic [63:0] t0, t1, t2, t3, t4;
		lanes_t res;
		x0 = s[0];
		x1 = s[1];
		x2 = s[2] ^ {56'd0, ~r, r};
		x3 = s[3];
		x4 = s[4];
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;
		res[0] = x0 ^ rotr64(x0, 19) ^ rotr64(x0, 28);
		res[1] = x1 ^ rotr64(x1, 61) ^ rotr64(x1, 39);
		res[2] = x2 ^ rotr64(x2, 1) ^ rotr64(x2, 6);
		res[3] = x3 ^ rotr64(x3, 10) ^ rotr64(x3, 17);
		res[4] = x4 ^ rotr64(x4, 7) ^ rotr64(x4, 41);
		return res;
	endfunction

endpackage

>>> hw/rtl/axof_in_if.sv
interface axof_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] msg_word;
	logic [3:0]  byte_count;
	logic        last;

	modport source (output valid, msg_word, byte_count, last, input ready);
	modport sink (input valid, msg_word, byte_count, last, output ready);
endinterface

>>> hw/rtl/axof_out_if.sv
interface axof_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [3:0]  digest_bytes;
	logic        digest_last;

	modport source (output valid, digest_word, digest_bytes, digest_last, input ready);
	modport sink (input valid, digest_word, digest_bytes, digest_last, output ready);
endinterface

>>> hw/rtl/axof_front.sv
module axof_front
	import axof_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	axof_in_if.sink     msg,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	cmd_t            cls;
	logic            push;
	logic            pop;

	// classify the item: padding is folded in when the word is partial
	always_comb begin
		cls.word = msg.msg_word;
		cls.kind = CMD_ABSORB;
		if (msg.last) begin
			if (msg.byte_count >= 4'd8) begin
				cls.kind = CMD_FINAL_FULL;
			end else begin
				cls.kind = CMD_FINAL;
				cls.word = (msg.msg_word & byte_mask(msg.byte_count))
					^ (64'd1 << {msg.byte_count[2:0], 3'b000});
			end
		end
	end

	assign msg.ready = (cnt_q != Q_DEPTH[Q_AW:0]);
	assign push      = msg.valid && msg.ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_DEPTH[Q_AW:0])
		else $error("queue count above depth");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");
	a_pop_track: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a pop");
`endif

endmodule

>>> hw/rtl/axof_back.sv
module axof_back
	import axof_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [8:0]  out_len,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	axof_out_if.source  dig
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PERM = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t      state_q;
	lanes_t      lanes_q;
	lanes_t      rnd_out;
	logic [3:0]  rnd_q;
	logic        pad_pend_q;
	logic        squeeze_q;
	logic [8:0]  rem_q;
	logic [8:0]  len_clamped;
	logic        rnd_last;
	logic        emit_load;
	logic        rem_final;
	logic [3:0]  nb;
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_bytes_q;
	logic        out_last_q;

	assign rnd_out  = ascon_round(lanes_q, rnd_q);
	assign rnd_last = (rnd_q == 4'(NUM_ROUNDS - 1));

	// digest length clamped to 1..256
	always_comb begin
		len_clamped = out_len;
		if (out_len == '0) begin
			len_clamped = 9'd1;
		end else if (out_len > OUT_LEN_MAX) begin
			len_clamped = OUT_LEN_MAX;
		end
	end

	// take a command when idle, or straight after an absorb permutation
	assign cmd_ready = (state_q == S_IDLE)
		|| (state_q == S_PERM && rnd_last && !pad_pend_q && !squeeze_q);

	assign rem_final = (rem_q <= 9'd8);
	assign nb        = rem_final ? rem_q[3:0] : 4'd8;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || dig.ready);

	// sponge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lanes_q    <= IV_LANES;
			rnd_q      <= '0;
			pad_pend_q <= 1'b0;
			squeeze_q  <= 1'b0;
			rem_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						lanes_q[0] <= lanes_q[0] ^ cmd.word;
						rnd_q      <= '0;
						squeeze_q  <= (cmd.kind != CMD_ABSORB);
						pad_pend_q <= (cmd.kind == CMD_FINAL_FULL);
						rem_q      <= len_clamped;
						state_q    <= S_PERM;
					end
				end
				S_PERM: begin
					if (!rnd_last) begin
						lanes_q <= rnd_out;
						rnd_q   <= rnd_q + 1'b1;
					end else begin
						rnd_q <= '0;
						if (pad_pend_q) begin
							lanes_q    <= {rnd_out[4:1], rnd_out[0] ^ 64'd1};
							pad_pend_q <= 1'b0;
						end else if (squeeze_q) begin
							lanes_q <= rnd_out;
							state_q <= S_EMIT;
						end else if (cmd_valid) begin
							lanes_q    <= {rnd_out[4:1], rnd_out[0] ^ cmd.word};
							squeeze_q  <= (cmd.kind != CMD_ABSORB);
							pad_pend_q <= (cmd.kind == CMD_FINAL_FULL);
							rem_q      <= len_clamped;
						end else begin
							lanes_q <= rnd_out;
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						if (rem_final) begin
							lanes_q   <= IV_LANES;
							squeeze_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							rem_q   <= rem_q - 9'd8;
							rnd_q   <= '0;
							state_q <= S_PERM;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (dig.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q  <= lanes_q[0] & byte_mask(nb);
			out_bytes_q <= nb;
			out_last_q  <= rem_final;
		end
	end

	assign dig.valid        = out_valid_q;
	assign dig.digest_word  = out_word_q;
	assign dig.digest_bytes = out_bytes_q;
	assign dig.digest_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_idle_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> rnd_q == '0 && !pad_pend_q && !squeeze_q)
		else $error("idle with round or pad pending");
	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> rem_q != '0 && squeeze_q)
		else $error("squeeze with nothing left");
	a_iv_back: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && rem_final) |=> lanes_q == IV_LANES && state_q == S_IDLE)
		else $error("state not back at iv after last digest item");
`endif

endmodule

>>> hw/rtl/ascon_xof128_hash.sv
// absorb: from idle, a word is xored in and permuted; when the queue keeps
// the permutation busy, the next word is taken in its last round (one round
// per cycle in the back end); a partial last item is permuted with the pad
// folded in (a full eight-byte word adds a permutation for the pad alone),
// digest items load when the output is free, each after a permutation
// reset: sponge state returns to the iv, queue and output empty, length 32
module ascon_xof128_hash
	import axof_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	axof_in_if.sink            msg,
	axof_out_if.source         dig,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [8:0] out_len_q;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_t       cmd;

	assign pready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q <= OUT_LEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_LEN) begin
			out_len_q <= pwdata[8:0];
		end
	end

	assign prdata = (paddr[2] == REG_OUT_LEN) ? {23'd0, out_len_q} : 32'd0;

	axof_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	axof_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_len   (out_len_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.dig       (dig)
	);

endmodule
